[rtl/assert_macros.svh]
// Assertion macros used by the detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLKD(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLKD(name, prop, msg)
`define ASSERT_CLK(name, prop, msg)
`endif

`endif

[rtl/ccfar_pkg.sv]
// Package with the constants, types and geometry function of the CFAR detector.
package ccfar_pkg;

	localparam int MAX_CELLS     = 64;
	localparam int SAMPLE_BITS   = 12;
	localparam int IDX_BITS      = $clog2(MAX_CELLS);
	localparam int TREE_LEVELS   = IDX_BITS;
	localparam int TREE_LEAVES   = 1 << TREE_LEVELS;
	localparam int SUM_BITS      = SAMPLE_BITS + IDX_BITS;
	localparam int WL_BITS       = 7;
	localparam int GUARD_BITS    = 5;
	localparam int CUT_BITS      = 6;
	localparam int SCALE_BITS    = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int THR_BITS      = 42;
	localparam int FRAC_BITS     = 16;
	localparam int CALC_BITS     = ((IDX_BITS > GUARD_BITS) ? IDX_BITS : GUARD_BITS) + 2;
	localparam int PIPE_STAGES   = TREE_LEVELS + 3;

	localparam logic [WL_BITS-1:0]    RESET_WL    = WL_BITS'(16);
	localparam logic [GUARD_BITS-1:0] RESET_GUARD = GUARD_BITS'(2);
	localparam logic [CUT_BITS-1:0]   RESET_CUT   = CUT_BITS'(8);
	localparam logic [SCALE_BITS-1:0] RESET_SCALE = SCALE_BITS'(65536);

	typedef enum logic [1:0] {
		REG_WINDOW_LENGTH   = 2'd0,
		REG_GUARD_CELLS     = 2'd1,
		REG_CUT_INDEX       = 2'd2,
		REG_THRESHOLD_SCALE = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                front_ok;
		logic [IDX_BITS-1:0] front_end;
		logic                back_ok;
		logic [IDX_BITS-1:0] back_start;
		logic [IDX_BITS-1:0] last;
		logic [IDX_BITS-1:0] cut;
		logic [IDX_BITS-1:0] warm_load;
	} geom_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] fmax;
		logic [SAMPLE_BITS-1:0] bmax;
		logic [SUM_BITS-1:0]    sum;
		logic [SAMPLE_BITS-1:0] cutv;
	} node_t;

	function automatic geom_t calc_geom(logic [WL_BITS-1:0] wl, logic [GUARD_BITS-1:0] gc,
			logic [CUT_BITS-1:0] ci);
		logic [CALC_BITS-1:0] n;
		logic [CALC_BITS-1:0] c;
		logic [CALC_BITS-1:0] g;
		logic [CALC_BITS-1:0] bs;
		geom_t r;
		n = CALC_BITS'(wl);
		if (n < CALC_BITS'(3)) begin
			n = CALC_BITS'(3);
		end
		if (n > CALC_BITS'(MAX_CELLS)) begin
			n = CALC_BITS'(MAX_CELLS);
		end
		c = CALC_BITS'(ci);
		if (c < CALC_BITS'(1)) begin
			c = CALC_BITS'(1);
		end
		if (c > n - CALC_BITS'(2)) begin
			c = n - CALC_BITS'(2);
		end
		g = CALC_BITS'(gc);
		bs = c + g + CALC_BITS'(1);
		r.front_ok   = g < c;
		r.front_end  = IDX_BITS'(c - g - CALC_BITS'(1));
		r.back_ok    = bs <= n - CALC_BITS'(1);
		r.back_start = IDX_BITS'(bs);
		r.last       = IDX_BITS'(n - CALC_BITS'(1));
		r.cut        = IDX_BITS'(c);
		r.warm_load  = IDX_BITS'(c + CALC_BITS'(1));
		return r;
	endfunction

	localparam geom_t RESET_GEOM = calc_geom(RESET_WL, RESET_GUARD, RESET_CUT);

endpackage

[rtl/ccfar_cell.sv]
// One window cell: holds a sample, passes it on, and classifies its next value.
module ccfar_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  logic                             shift,
	input  logic [ccfar_pkg::SAMPLE_BITS-1:0] din,
	input  logic [ccfar_pkg::IDX_BITS-1:0]    idx,
	input  ccfar_pkg::geom_t                  geom,
	output logic [ccfar_pkg::SAMPLE_BITS-1:0] dout,
	output ccfar_pkg::node_t                  leaf
);
	import ccfar_pkg::*;

	logic [SAMPLE_BITS-1:0] value_q;
	logic                   in_front;
	logic                   in_back;
	logic                   at_cut;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (clear) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= din;
		end
	end

	assign dout     = value_q;
	assign in_front = geom.front_ok && (idx <= geom.front_end);
	assign in_back  = geom.back_ok && (idx >= geom.back_start) && (idx <= geom.last);
	assign at_cut   = idx == geom.cut;

	always_comb begin
		leaf.fmax = in_front ? din : '0;
		leaf.bmax = in_back ? din : '0;
		leaf.sum  = (in_front || in_back) ? SUM_BITS'(din) : '0;
		leaf.cutv = at_cut ? din : '0;
	end

endmodule

[rtl/ccfar_tree.sv]
// Registered reduction tree: region maxima, reference sum and test cell value.
module ccfar_tree (
	input  logic                             clk,
	input  logic [ccfar_pkg::TREE_LEVELS-1:0] en,
	input  ccfar_pkg::node_t                  leaf [ccfar_pkg::TREE_LEAVES],
	output ccfar_pkg::node_t                  root
);
	import ccfar_pkg::*;

	function automatic node_t combine(node_t a, node_t b);
		node_t r;
		r.fmax = (a.fmax > b.fmax) ? a.fmax : b.fmax;
		r.bmax = (a.bmax > b.bmax) ? a.bmax : b.bmax;
		r.sum  = a.sum + b.sum;
		r.cutv = a.cutv | b.cutv;
		return r;
	endfunction

	node_t node_q [TREE_LEAVES-1];

	for (genvar d = 0; d < TREE_LEVELS; d++) begin : g_lvl
		for (genvar i = 0; i < (1 << d); i++) begin : g_node
			localparam int K = (1 << d) - 1 + i;
			if (d == TREE_LEVELS - 1) begin : g_bottom
				always_ff @(posedge clk) begin
					if (en[0]) begin
						node_q[K] <= combine(leaf[2*i], leaf[2*i+1]);
					end
				end
			end else begin : g_inner
				localparam int C = (1 << (d + 1)) - 1 + 2 * i;
				always_ff @(posedge clk) begin
					if (en[TREE_LEVELS-1-d]) begin
						node_q[K] <= combine(node_q[C], node_q[C+1]);
					end
				end
			end
		end
	end

	assign root = node_q[0];

endmodule

[rtl/censored_cell_average_cfar_detector.sv]
// Top level of the censored cell-averaging CFAR detector.
//
//   channel  direction  handshake            word
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid/in_ready    sample
//   out      out        out_valid/out_ready  detected, threshold_value, test_cell_value,
//                                            window_ready
//
// One sample is taken per cycle while in_ready is high; its word passes through the registered levels
// of the reduction tree, then subtract, multiply and compare.
// Each stage has its own valid bit and moves when the stage after it is empty or moving,
// so bubbles are squeezed out and a held output word stops the input only when all stages are full.
// Reset clears the window and loads the power-on geometry; a geometry register write clears the
// window and reloads the warm-up count in the same cycle.
`include "assert_macros.svh"

module censored_cell_average_cfar_detector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  ccfar_pkg::cfg_reg_t                cfg_index,
	input  logic [ccfar_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ccfar_pkg::SAMPLE_BITS-1:0]   sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               detected,
	output logic [ccfar_pkg::THR_BITS-1:0]      threshold_value,
	output logic [ccfar_pkg::SAMPLE_BITS-1:0]   test_cell_value,
	output logic                               window_ready
);
	import ccfar_pkg::*;

	logic [WL_BITS-1:0]    wl_q;
	logic [WL_BITS-1:0]    wl_d;
	logic [GUARD_BITS-1:0] gc_q;
	logic [GUARD_BITS-1:0] gc_d;
	logic [CUT_BITS-1:0]   ci_q;
	logic [CUT_BITS-1:0]   ci_d;
	logic [SCALE_BITS-1:0] scale_q;
	geom_t                 geom;
	geom_t                 geom_d;
	logic                  geo_wr;
	logic                  accept;

	logic [IDX_BITS-1:0]   warm_q;
	logic                  warm_done;

	logic [SAMPLE_BITS-1:0] din_w [MAX_CELLS];
	logic [SAMPLE_BITS-1:0] win [MAX_CELLS];
	node_t                  leaf [TREE_LEAVES];
	node_t                  root;

	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] en;
	logic [TREE_LEVELS-1:0] warm_pipe_q;

	logic [SUM_BITS-1:0]            diff_s1;
	logic [SAMPLE_BITS-1:0]         cutv_s1;
	logic                           rdy_s1;
	logic [SUM_BITS+SCALE_BITS-1:0] prod;
	logic [THR_BITS-1:0]            thr_s2;
	logic [SAMPLE_BITS-1:0]         cutv_s2;
	logic                           rdy_s2;
	logic [SAMPLE_BITS-1:0]         big;

	logic                   detected_q;
	logic [THR_BITS-1:0]    thr_q;
	logic [SAMPLE_BITS-1:0] cutv_q;
	logic                   wready_q;

	always_comb begin
		wl_d = wl_q;
		gc_d = gc_q;
		ci_d = ci_q;
		if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: wl_d = cfg_data[WL_BITS-1:0];
				REG_GUARD_CELLS: gc_d = cfg_data[GUARD_BITS-1:0];
				REG_CUT_INDEX: ci_d = cfg_data[CUT_BITS-1:0];
				REG_THRESHOLD_SCALE: begin
				end
			endcase
		end
	end

	assign geo_wr = cfg_write && (cfg_index != REG_THRESHOLD_SCALE);
	assign geom   = calc_geom(wl_q, gc_q, ci_q);
	assign geom_d = calc_geom(wl_d, gc_d, ci_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= RESET_WL;
			gc_q    <= RESET_GUARD;
			ci_q    <= RESET_CUT;
			scale_q <= RESET_SCALE;
		end else begin
			wl_q <= wl_d;
			gc_q <= gc_d;
			ci_q <= ci_d;
			if (cfg_write && (cfg_index == REG_THRESHOLD_SCALE)) begin
				scale_q <= cfg_data[SCALE_BITS-1:0];
			end
		end
	end

	always_comb begin
		en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_ready;
		for (int t = PIPE_STAGES - 2; t >= 0; t--) begin
			en[t] = !vld_q[t] || en[t+1];
		end
	end

	assign in_ready = en[0];
	assign accept   = in_valid && en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int t = 1; t < PIPE_STAGES; t++) begin
				if (en[t]) begin
					vld_q[t] <= vld_q[t-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= RESET_GEOM.warm_load;
		end else if (geo_wr) begin
			warm_q <= geom_d.warm_load;
		end else if (accept && (warm_q != '0)) begin
			warm_q <= warm_q - IDX_BITS'(1);
		end
	end

	assign warm_done = warm_q <= IDX_BITS'(1);

	assign din_w[0] = sample;
	for (genvar j = 1; j < MAX_CELLS; j++) begin : g_link
		assign din_w[j] = win[j-1];
	end

	for (genvar j = 0; j < TREE_LEAVES; j++) begin : g_cell
		if (j < MAX_CELLS) begin : g_used
			ccfar_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.clear  (geo_wr),
				.shift  (accept),
				.din    (din_w[j]),
				.idx    (IDX_BITS'(j)),
				.geom   (geom),
				.dout   (win[j]),
				.leaf   (leaf[j])
			);
		end else begin : g_pad
			assign leaf[j] = '0;
		end
	end

	ccfar_tree u_tree (
		.clk  (clk),
		.en   (en[TREE_LEVELS-1:0]),
		.leaf (leaf),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			warm_pipe_q[0] <= warm_done;
		end
		for (int t = 1; t < TREE_LEVELS; t++) begin
			if (en[t]) begin
				warm_pipe_q[t] <= warm_pipe_q[t-1];
			end
		end
	end

	assign big = (root.fmax > root.bmax) ? root.fmax : root.bmax;

	always_ff @(posedge clk) begin
		if (en[TREE_LEVELS]) begin
			diff_s1 <= root.sum - SUM_BITS'(big);
			cutv_s1 <= root.cutv;
			rdy_s1  <= warm_pipe_q[TREE_LEVELS-1];
		end
	end

	assign prod = diff_s1 * scale_q;

	always_ff @(posedge clk) begin
		if (en[TREE_LEVELS+1]) begin
			thr_s2  <= THR_BITS'(prod);
			cutv_s2 <= cutv_s1;
			rdy_s2  <= rdy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_STAGES-1]) begin
			detected_q <= THR_BITS'({cutv_s2, {FRAC_BITS{1'b0}}}) > thr_s2;
			thr_q      <= thr_s2;
			cutv_q     <= cutv_s2;
			wready_q   <= rdy_s2;
		end
	end

	assign out_valid       = vld_q[PIPE_STAGES-1];
	assign detected        = detected_q;
	assign threshold_value = thr_q;
	assign test_cell_value = cutv_q;
	assign window_ready    = wready_q;

	`ASSERT_CLKD(a_warm_no_rise, !geo_wr |=> (warm_q <= $past(warm_q)), "warm-up count rose without a geometry write")
	`ASSERT_CLKD(a_warm_reload, geo_wr |=> (warm_q == geom.warm_load), "warm-up count not reloaded after a geometry write")
	`ASSERT_CLKD(a_full_stall, ((&vld_q) && !out_ready) |-> !in_ready, "input taken while every stage is full and the output word is held")
	`ASSERT_CLK(a_ready_chain, (!vld_q[0]) |-> in_ready, "input refused while the first stage is empty")

endmodule
